/* sv/kfr_pkg.sv */
// ----------------------------------------------------------------------------
// kfr_pkg
// shared types and constants of the keyframe ramp generator
// ----------------------------------------------------------------------------
`default_nettype none
package kfr_pkg;
	localparam int QUEUE_DEPTH = 8;
	localparam int PTR_W       = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
	localparam int CNT_W       = $clog2(QUEUE_DEPTH + 1);
	localparam int TICK_W      = 20;
	localparam int VAL_W       = 32;
	localparam int MAG_W       = VAL_W + 1;
	localparam int FRAC_W      = 2 * TICK_W;

	localparam logic [1:0] OP_LIN   = 2'd0;
	localparam logic [1:0] OP_QUAD  = 2'd1;
	localparam logic [1:0] OP_TICK  = 2'd2;
	localparam logic [1:0] OP_TRUNC = 2'd3;

	typedef struct packed {
		logic                    kind;
		logic [TICK_W-1:0]       len;
		logic signed [VAL_W-1:0] target;
	} entry_t;

	localparam int ENTRY_W = $bits(entry_t);

	function automatic logic [3:0] sat4(input logic [CNT_W-1:0] v);
		logic [CNT_W+3:0] w;
		w = {4'd0, v};
		return (w > 15) ? 4'd15 : w[3:0];
	endfunction
endpackage
`default_nettype wire

/* sv/kfr_if.sv */
// ----------------------------------------------------------------------------
// kfr_in_if / kfr_out_if
// valid/ready channels for input items and result items
// ----------------------------------------------------------------------------
`default_nettype none
interface kfr_in_if;
	logic                               valid;
	logic                               ready;
	logic [1:0]                         op;
	logic signed [kfr_pkg::VAL_W-1:0]   target;
	logic [kfr_pkg::TICK_W-1:0]         frame_ticks;
	logic [kfr_pkg::TICK_W-1:0]         delta_ticks;
	modport source (output valid, op, target, frame_ticks, delta_ticks, input ready);
	modport sink (input valid, op, target, frame_ticks, delta_ticks, output ready);
endinterface

interface kfr_out_if;
	logic                               valid;
	logic                               ready;
	logic signed [kfr_pkg::VAL_W-1:0]   value;
	logic                               changed;
	logic [3:0]                         frames_done;
	logic                               rejected;
	logic [3:0]                         pending;
	modport source (output valid, value, changed, frames_done, rejected, pending,
		input ready);
	modport sink (input valid, value, changed, frames_done, rejected, pending,
		output ready);
endinterface
`default_nettype wire

/* sv/kfr_ram.sv */
// ----------------------------------------------------------------------------
// kfr_ram
// generic single-write, single-read ram with registered read data
// ----------------------------------------------------------------------------
`default_nettype none
module kfr_ram #(
	parameter int WIDTH = 8,
	parameter int DEPTH = 8
) (
	input  wire logic                                   clk,
	input  wire logic                                   we,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
	input  wire logic [WIDTH-1:0]                       wdata,
	input  wire logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
	output logic [WIDTH-1:0]                            rdata
);
	logic [WIDTH-1:0] mem [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata <= mem[raddr];
	end
endmodule
`default_nettype wire

/* sv/kfr_scale.sv */
// ----------------------------------------------------------------------------
// kfr_scale
// bit-serial floor(mag * num / den) for num < den, one bit of mag per cycle
// ----------------------------------------------------------------------------
`default_nettype none
module kfr_scale (
	input  wire logic                        clk,
	input  wire logic                        arst_n,
	input  wire logic                        start,
	input  wire logic [kfr_pkg::MAG_W-1:0]   mag,
	input  wire logic [kfr_pkg::FRAC_W-1:0]  num,
	input  wire logic [kfr_pkg::FRAC_W-1:0]  den,
	output logic                             done,
	output logic [kfr_pkg::MAG_W-1:0]        q
);
	import kfr_pkg::*;

	localparam int CW = $clog2(MAG_W);

	logic              busy_q;
	logic [CW-1:0]     cnt_q;
	logic [MAG_W-1:0]  mag_q;
	logic [FRAC_W-1:0] num_q;
	logic [FRAC_W-1:0] den_q;
	logic [FRAC_W:0]   r_q;
	logic [MAG_W-1:0]  q_q;
	logic              done_q;

	logic [FRAC_W:0]   dr, r1, dn, r2;
	logic              b1, b2;

	always_comb begin
		// doubling step, remainder kept below den
		dr = {1'b0, den_q} - r_q;
		b1 = (r_q >= dr);
		r1 = b1 ? (r_q - dr) : (r_q + r_q);
		// add num when this bit of mag is set
		dn = {1'b0, den_q} - {1'b0, num_q};
		b2 = mag_q[MAG_W-1] && (r1 >= dn);
		if (!mag_q[MAG_W-1]) begin
			r2 = r1;
		end else if (b2) begin
			r2 = r1 - dn;
		end else begin
			r2 = r1 + {1'b0, num_q};
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			busy_q <= 1'b0;
			done_q <= 1'b0;
			cnt_q  <= '0;
		end else begin
			done_q <= 1'b0;
			if (start) begin
				busy_q <= 1'b1;
				cnt_q  <= CW'(MAG_W - 1);
			end else if (busy_q) begin
				cnt_q <= cnt_q - 1'b1;
				if (cnt_q == '0) begin
					busy_q <= 1'b0;
					done_q <= 1'b1;
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (start) begin
			mag_q <= mag;
			num_q <= num;
			den_q <= den;
			r_q   <= '0;
			q_q   <= '0;
		end else if (busy_q) begin
			mag_q <= {mag_q[MAG_W-2:0], 1'b0};
			r_q   <= r2;
			q_q   <= {q_q[MAG_W-2:0], 1'b0} + MAG_W'(b1) + MAG_W'(b2);
		end
	end

	assign done = done_q;
	assign q    = q_q;
endmodule
`default_nettype wire

/* sv/keyframe_ramp_generator.sv */
// ----------------------------------------------------------------------------
// keyframe_ramp_generator
// animated q16.16 value driven by a queue of linear / ease-out keyframes
// ----------------------------------------------------------------------------
// One item at a time. Appends and truncates go from idle to the finish state.
// A tick visits the check state once per retired frame and, when a frame
// remains active, goes on through the multiply and divide states, where a
// bit-serial scaler handles one of the 33 magnitude bits per cycle. Keyframes
// sit in a ram with registered read data, read once per visited frame. A new
// item is taken while the previous result waits in the output register.
`default_nettype none
module keyframe_ramp_generator (
	input  wire logic                         clk,
	input  wire logic                         arst_n,
	input  wire logic                         cfg_we,
	input  wire logic [kfr_pkg::VAL_W-1:0]    cfg_wdata,
	kfr_in_if.sink                            in_ch,
	kfr_out_if.source                         out_ch
);
	import kfr_pkg::*;

	localparam logic [2:0] S_IDLE = 3'd0;
	localparam logic [2:0] S_CHK  = 3'd1;
	localparam logic [2:0] S_MUL  = 3'd2;
	localparam logic [2:0] S_DIV  = 3'd3;
	localparam logic [2:0] S_FIN  = 3'd4;

	logic [2:0]              st_q;
	logic signed [VAL_W-1:0] cur_q, base_q;
	logic [TICK_W-1:0]       elapsed_q, dt_q;
	logic [PTR_W-1:0]        head_q;
	logic [CNT_W-1:0]        count_q, done_q;
	logic                    changed_q, rej_q;

	logic [TICK_W-1:0]       d_q, t_q;
	logic signed [VAL_W-1:0] tgt_q;
	logic                    kind_q;
	logic [MAG_W-1:0]        mag_q;
	logic                    neg_q;
	logic [FRAC_W-1:0]       num_q, den_q;
	logic                    div_start_q;

	logic                    out_valid_q;
	logic signed [VAL_W-1:0] o_value_q;
	logic                    o_changed_q, o_rej_q;
	logic [3:0]              o_done_q, o_pend_q;

	logic                    accept, we, div_done, head_wrap, out_free;
	logic [PTR_W-1:0]        raddr, head_next, slot;
	logic [PTR_W:0]          slot_sum;
	entry_t                  wentry, rentry;
	logic [TICK_W-1:0]       rem;
	logic [TICK_W:0]         two_d_mt;
	logic signed [MAG_W-1:0] delta;
	logic [MAG_W-1:0]        q;

	assign accept    = in_ch.valid && in_ch.ready;
	assign in_ch.ready = (st_q == S_IDLE);
	assign out_free  = !out_valid_q || out_ch.ready;
	assign head_wrap = (head_q == PTR_W'(QUEUE_DEPTH - 1));
	assign head_next = head_wrap ? '0 : head_q + 1'b1;
	assign slot_sum  = {1'b0, head_q} + (PTR_W + 1)'(count_q);
	assign slot      = (slot_sum >= (PTR_W + 1)'(QUEUE_DEPTH))
		? PTR_W'(slot_sum - (PTR_W + 1)'(QUEUE_DEPTH)) : slot_sum[PTR_W-1:0];
	assign we        = accept && (in_ch.op == OP_LIN || in_ch.op == OP_QUAD)
		&& (count_q < CNT_W'(QUEUE_DEPTH));
	assign wentry    = '{kind: (in_ch.op == OP_QUAD), len: in_ch.frame_ticks,
		target: in_ch.target};
	assign raddr     = (st_q == S_CHK) ? head_next : head_q;
	assign rem       = (rentry.len > elapsed_q) ? rentry.len - elapsed_q : '0;
	assign two_d_mt  = {d_q, 1'b0} - {1'b0, t_q};
	assign delta     = {tgt_q[VAL_W-1], tgt_q} - {base_q[VAL_W-1], base_q};

	kfr_ram #(.WIDTH(ENTRY_W), .DEPTH(QUEUE_DEPTH)) u_ram (
		.clk   (clk),
		.we    (we),
		.waddr (slot),
		.wdata (wentry),
		.raddr (raddr),
		.rdata (rentry)
	);

	kfr_scale u_scale (
		.clk    (clk),
		.arst_n (arst_n),
		.start  (div_start_q),
		.mag    (mag_q),
		.num    (num_q),
		.den    (den_q),
		.done   (div_done),
		.q      (q)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q        <= S_IDLE;
			cur_q       <= '0;
			base_q      <= '0;
			elapsed_q   <= '0;
			head_q      <= '0;
			count_q     <= '0;
			done_q      <= '0;
			changed_q   <= 1'b0;
			rej_q       <= 1'b0;
			div_start_q <= 1'b0;
			out_valid_q <= 1'b0;
		end else begin
			div_start_q <= 1'b0;
			if (out_ch.ready) begin
				out_valid_q <= 1'b0;
			end
			if (cfg_we && count_q == '0) begin
				cur_q  <= cfg_wdata;
				base_q <= cfg_wdata;
			end
			unique case (st_q)
				S_IDLE: begin
					if (accept) begin
						done_q    <= '0;
						changed_q <= 1'b0;
						rej_q     <= 1'b0;
						dt_q      <= in_ch.delta_ticks;
						st_q      <= S_FIN;
						unique case (in_ch.op)
							OP_LIN, OP_QUAD: begin
								if (we) begin
									count_q <= count_q + 1'b1;
								end else begin
									rej_q <= 1'b1;
								end
							end
							OP_TICK: begin
								if (count_q != '0) begin
									st_q <= S_CHK;
								end
							end
							default: begin
								count_q   <= '0;
								head_q    <= '0;
								elapsed_q <= '0;
								base_q    <= cur_q;
							end
						endcase
					end
				end
				S_CHK: begin
					changed_q <= 1'b1;
					if (dt_q >= rem) begin
						// head frame finishes within this tick
						dt_q      <= dt_q - rem;
						base_q    <= rentry.target;
						cur_q     <= rentry.target;
						elapsed_q <= '0;
						head_q    <= head_next;
						count_q   <= count_q - 1'b1;
						done_q    <= done_q + 1'b1;
						if (count_q == CNT_W'(1)) begin
							st_q <= S_FIN;
						end
					end else begin
						d_q       <= rentry.len;
						t_q       <= elapsed_q + dt_q;
						elapsed_q <= elapsed_q + dt_q;
						tgt_q     <= rentry.target;
						kind_q    <= rentry.kind;
						st_q      <= S_MUL;
					end
				end
				S_MUL: begin
					neg_q       <= delta[MAG_W-1];
					mag_q       <= delta[MAG_W-1] ? MAG_W'(-delta) : MAG_W'(delta);
					num_q       <= kind_q ? FRAC_W'(t_q) * FRAC_W'(two_d_mt)
						: FRAC_W'(t_q);
					den_q       <= kind_q ? FRAC_W'(d_q) * FRAC_W'(d_q) : FRAC_W'(d_q);
					div_start_q <= 1'b1;
					st_q        <= S_DIV;
				end
				S_DIV: begin
					if (div_done) begin
						cur_q <= neg_q ? base_q - VAL_W'(q) : base_q + VAL_W'(q);
						st_q  <= S_FIN;
					end
				end
				S_FIN: begin
					if (out_free) begin
						out_valid_q <= 1'b1;
						o_value_q   <= cur_q;
						o_changed_q <= changed_q;
						o_done_q    <= sat4(done_q);
						o_rej_q     <= rej_q;
						o_pend_q    <= sat4(count_q);
						st_q        <= S_IDLE;
					end
				end
				default: begin
					st_q <= S_IDLE;
				end
			endcase
		end
	end

	assign out_ch.valid       = out_valid_q;
	assign out_ch.value       = o_value_q;
	assign out_ch.changed     = o_changed_q;
	assign out_ch.frames_done = o_done_q;
	assign out_ch.rejected    = o_rej_q;
	assign out_ch.pending     = o_pend_q;

`ifndef SYNTHESIS
	a_count_bound: assert property (@(posedge clk) disable iff (!arst_n)
		count_q <= CNT_W'(QUEUE_DEPTH))
		else $error("frame count above queue depth");
	a_reject_full: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && o_rej_q |-> o_pend_q == sat4(CNT_W'(QUEUE_DEPTH)))
		else $error("append rejected while queue not full");
	a_done_changed: assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && o_done_q != 4'd0 |-> o_changed_q)
		else $error("frames retired without change flag");
	a_div_state: assert property (@(posedge clk) disable iff (!arst_n)
		div_done |-> st_q == S_DIV)
		else $error("scaler finished outside its state");
`endif
endmodule
`default_nettype wire

/* dv/kfr_tb_if.sv */
// ----------------------------------------------------------------------------
// kfr_tb_if
// package of shared bench types for the keyframe ramp generator bench
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
// the channel interfaces themselves come from sv/kfr_if.sv; this file only
// gives the bench a place after the package for shared bench types
package kfr_tb_pkg;
	import kfr_pkg::*;

	typedef struct {
		logic signed [VAL_W-1:0] value;
		logic                    changed;
		logic [3:0]              frames_done;
		logic                    rejected;
		logic [3:0]              pending;
	} ramp_out_t;
endpackage

/* dv/keyframe_ramp_generator_tb.sv */
// ----------------------------------------------------------------------------
// keyframe_ramp_generator_tb
// checks the keyframe ramp generator against a cycle-free predictor: appends,
// ticks and truncates are driven with random stalls on both channels and
// every result item is compared field by field
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module keyframe_ramp_generator_tb;
	import kfr_pkg::*;
	import kfr_tb_pkg::*;

	localparam int WATCHDOG = 20000;

	class ramp_scoreboard;
		logic signed [VAL_W-1:0]  f_target [QUEUE_DEPTH];
		logic [TICK_W-1:0]        f_len [QUEUE_DEPTH];
		logic                     f_quad [QUEUE_DEPTH];
		logic [63:0]              elapsed;
		longint                   cur, base, init_val;
		int                       head, count;
		ramp_out_t                expected_q [$];
		int                       errors;
		int                       checked;

		function void clear();
			elapsed = 0; head = 0; count = 0;
			cur = 0; base = 0; init_val = 0;
			errors = 0; checked = 0;
			expected_q.delete();
		endfunction

		function void load_initial(logic [VAL_W-1:0] v);
			init_val = longint'($signed(v));
			if (count == 0) begin
				cur = init_val;
				base = init_val;
			end
		endfunction

		// floor(mag*num/den), num <= den
		function longint unsigned ramp_fraction(longint unsigned mag, logic [63:0] num,
				logic [63:0] den);
			logic [127:0] p;
			if (den == 0 || num == 0) return 0;
			p = 128'(mag) * 128'(num);
			return longint'(p / 128'(den));
		endfunction

		function void note_item(logic [1:0] op, logic [VAL_W-1:0] tgt,
				logic [TICK_W-1:0] ft, logic [TICK_W-1:0] dtk);
			ramp_out_t r;
			logic [63:0] dt, rem, d, t;
			longint delta;
			longint unsigned mag, q;
			int done, slot;
			done = 0;
			r.changed = 0;
			r.rejected = 0;
			if (op == OP_LIN || op == OP_QUAD) begin
				if (count >= QUEUE_DEPTH) begin
					r.rejected = 1;
				end else begin
					slot = (head + count) % QUEUE_DEPTH;
					f_target[slot] = tgt;
					f_len[slot] = ft;
					f_quad[slot] = (op == OP_QUAD);
					count++;
				end
			end else if (op == OP_TICK) begin
				dt = dtk;
				while (count > 0) begin
					rem = (f_len[head] > elapsed) ? f_len[head] - elapsed : 0;
					if (dt < rem) break;
					dt -= rem;
					base = longint'(f_target[head]);
					cur = base;
					elapsed = 0;
					head = (head + 1) % QUEUE_DEPTH;
					count--;
					done++;
					r.changed = 1;
				end
				if (count > 0) begin
					d = f_len[head];
					t = elapsed + dt;
					delta = longint'(f_target[head]) - base;
					mag = (delta < 0) ? -delta : delta;
					elapsed = t;
					if (!f_quad[head]) q = ramp_fraction(mag, t, d);
					else q = ramp_fraction(mag, t * (2 * d - t), d * d);
					cur = (delta < 0) ? base - longint'(q) : base + longint'(q);
					r.changed = 1;
				end
			end else begin
				count = 0;
				head = 0;
				elapsed = 0;
				base = cur;
			end
			r.value = cur[VAL_W-1:0];
			r.frames_done = (done > 15) ? 4'd15 : done[3:0];
			r.pending = (count > 15) ? 4'd15 : count[3:0];
			expected_q.push_back(r);
		endfunction

		function void check_result(ramp_out_t a);
			ramp_out_t e;
			checked++;
			if (expected_q.size() == 0) begin
				$error("result item with nothing expected");
				errors++;
				return;
			end
			e = expected_q.pop_front();
			if (a.value !== e.value) begin
				$error("value expected %0h actual %0h", e.value, a.value); errors++;
			end
			if (a.changed !== e.changed) begin
				$error("changed expected %0d actual %0d", e.changed, a.changed); errors++;
			end
			if (a.frames_done !== e.frames_done) begin
				$error("frames_done expected %0d actual %0d", e.frames_done,
					a.frames_done);
				errors++;
			end
			if (a.rejected !== e.rejected) begin
				$error("rejected expected %0d actual %0d", e.rejected, a.rejected);
				errors++;
			end
			if (a.pending !== e.pending) begin
				$error("pending expected %0d actual %0d", e.pending, a.pending); errors++;
			end
		endfunction
	endclass

	logic clk;
	logic arst_n;
	logic cfg_we;
	logic [VAL_W-1:0] cfg_wdata;
	kfr_in_if in_ch();
	kfr_out_if out_ch();

	ramp_scoreboard sb;
	bit stall_enable;
	int idle_cycles;
	int ticks_sent, appends_sent, truncs_sent;

	keyframe_ramp_generator dut (
		.clk(clk), .arst_n(arst_n), .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
		.in_ch(in_ch), .out_ch(out_ch)
	);

	initial begin
		clk = 0;
		forever #5 clk = ~clk;
	end

	// sink side: random ready bursts, check on accept
	initial begin
		ramp_out_t r;
		out_ch.ready = 0;
		forever begin
			@(posedge clk);
			if (out_ch.valid && out_ch.ready) begin
				r.value = out_ch.value;
				r.changed = out_ch.changed;
				r.frames_done = out_ch.frames_done;
				r.rejected = out_ch.rejected;
				r.pending = out_ch.pending;
				sb.check_result(r);
			end
			if (stall_enable && $urandom_range(0, 7) == 0) begin
				out_ch.ready <= 0;
				repeat ($urandom_range(1, 17)) @(posedge clk);
				if (out_ch.valid && out_ch.ready) begin
					r.value = out_ch.value;
					r.changed = out_ch.changed;
					r.frames_done = out_ch.frames_done;
					r.rejected = out_ch.rejected;
					r.pending = out_ch.pending;
					sb.check_result(r);
				end
			end
			out_ch.ready <= 1;
		end
	end

	// watchdog on cycles without any accepted item
	initial begin
		idle_cycles = 0;
		forever begin
			@(posedge clk);
			if ((in_ch.valid && in_ch.ready) || (out_ch.valid && out_ch.ready))
				idle_cycles = 0;
			else
				idle_cycles++;
			if (idle_cycles >= WATCHDOG) begin
				$display("FAIL keyframe_ramp_generator");
				$finish;
			end
		end
	end

	task automatic send_item(logic [1:0] op, logic [VAL_W-1:0] tgt,
			logic [TICK_W-1:0] ft, logic [TICK_W-1:0] dtk);
		if (stall_enable && $urandom_range(0, 5) == 0) begin
			in_ch.valid <= 0;
			repeat ($urandom_range(1, 17)) @(posedge clk);
		end
		in_ch.valid <= 1;
		in_ch.op <= op;
		in_ch.target <= tgt;
		in_ch.frame_ticks <= ft;
		in_ch.delta_ticks <= dtk;
		do @(posedge clk); while (!in_ch.ready);
		sb.note_item(op, tgt, ft, dtk);
		case (op)
			OP_TICK: ticks_sent++;
			OP_TRUNC: truncs_sent++;
			default: appends_sent++;
		endcase
	endtask

	// drop valid after the last item of a phase and wait for all expected results
	task automatic go_quiet();
		in_ch.valid <= 0;
		while (sb.expected_q.size() != 0) @(posedge clk);
		repeat (60) @(posedge clk);
	endtask

	task automatic write_initial(logic [VAL_W-1:0] v);
		cfg_we <= 1;
		cfg_wdata <= v;
		@(posedge clk);
		sb.load_initial(v);
		cfg_we <= 0;
	endtask

	function automatic logic [TICK_W-1:0] rand_len();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2, 3: return TICK_W'($urandom_range(1, 4));
			default: return TICK_W'($urandom_range(1, 64));
		endcase
	endfunction

	function automatic logic [TICK_W-1:0] rand_dt();
		case ($urandom_range(0, 9))
			0: return '0;
			1: return '1;
			2: return TICK_W'($urandom);
			default: return TICK_W'($urandom_range(0, 40));
		endcase
	endfunction

	task automatic random_phase(int n);
		int kind;
		for (int i = 0; i < n; i++) begin
			kind = $urandom_range(0, 19);
			if (kind < 8)
				send_item(kind[0] ? OP_QUAD : OP_LIN, $urandom, rand_len(),
					TICK_W'($urandom));
			else if (kind < 19)
				send_item(OP_TICK, $urandom, TICK_W'($urandom), rand_dt());
			else
				send_item(OP_TRUNC, $urandom, TICK_W'($urandom), TICK_W'($urandom));
		end
	endtask

	initial begin
		sb = new();
		sb.clear();
		stall_enable = 1;
		ticks_sent = 0; appends_sent = 0; truncs_sent = 0;
		arst_n = 0;
		cfg_we = 0;
		cfg_wdata = '0;
		in_ch.valid = 0;
		in_ch.op = OP_TICK;
		in_ch.target = '0;
		in_ch.frame_ticks = '0;
		in_ch.delta_ticks = '0;
		repeat (3) @(posedge clk);
		arst_n <= 1;
		@(posedge clk);

		// directed: extremes, empty tick, zero-length frames, full queue, truncate
		write_initial(32'h8000_0000);
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_LIN, 32'h7fff_ffff, 20'd4, '0);
		send_item(OP_QUAD, 32'h8000_0000, '1, '0);
		send_item(OP_LIN, 32'h0001_0000, '0, '0);
		send_item(OP_TICK, '0, '0, 20'd1);
		send_item(OP_TICK, '0, '0, 20'd3);
		send_item(OP_TICK, '0, '0, 20'h7ffff);
		send_item(OP_TICK, '0, '0, '1);
		for (int i = 0; i < 9; i++)
			send_item(i[0] ? OP_QUAD : OP_LIN, $urandom, '0, '0);
		send_item(OP_TICK, '0, '0, '0);
		send_item(OP_QUAD, 32'hffff_0000, 20'd10, '0);
		send_item(OP_TICK, '0, '0, 20'd3);
		send_item(OP_TRUNC, '1, '1, '1);
		send_item(OP_TICK, '0, '0, 20'd5);
		go_quiet();

		write_initial(32'h7fff_ffff);
		random_phase(500);
		go_quiet();
		write_initial(32'h0000_0000);
		random_phase(500);
		go_quiet();
		write_initial($urandom);
		random_phase(400);
		go_quiet();
		// last stretch without idling
		stall_enable = 0;
		write_initial($urandom);
		random_phase(200);
		go_quiet();

		$display("covered %0d appends, %0d ticks, %0d truncates", appends_sent,
			ticks_sent, truncs_sent);
		$display("%0d result items checked, %0d mismatches", sb.checked, sb.errors);
		if (sb.errors == 0 && sb.expected_q.size() == 0)
			$display("PASS keyframe_ramp_generator");
		else
			$display("FAIL keyframe_ramp_generator");
		$finish;
	end
endmodule
